>>> hw/rtl/octahedral_normal_encoder_defines.svh
// ---------------------------------------------------------------------------
// Octahedral normal encoder assertion macros
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef OCTAHEDRAL_NORMAL_ENCODER_DEFINES_SVH
`define OCTAHEDRAL_NORMAL_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ONENC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("onenc assertion failed");

// next-cycle implication
`define ONENC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("onenc assertion failed");

`else

`define ONENC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ONENC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/onenc_pkg.sv
// ---------------------------------------------------------------------------
// Octahedral normal encoder package
// Widths, word types and flag bundles shared by the pipeline modules.
// ---------------------------------------------------------------------------
`default_nettype none

package onenc_pkg;

  // component width of the incoming normal
  localparam int COMP_BITS = 24;
  // L1 norm: three magnitudes of at most 2^(COMP_BITS-1) fit in one more bit
  localparam int SUM_BITS  = COMP_BITS + 1;
  // dividend 2*32767*mag + s stays below 2^16 * s
  localparam int NUM_BITS  = SUM_BITS + 16;
  // divisor 2*s
  localparam int DEN_BITS  = SUM_BITS + 1;
  // quotient never exceeds 32767
  localparam int QUOT_BITS = 15;
  localparam int HALF_BITS = 16;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] normal_z;
    logic signed [COMP_BITS-1:0] normal_y;
    logic signed [COMP_BITS-1:0] normal_x;
  } onenc_in_t;

  typedef struct packed {
    logic [2*HALF_BITS-1:0] packed_word;
    logic                   was_zero;
  } onenc_out_t;

  typedef struct packed {
    logic neg_u;
    logic neg_v;
    logic zero;
  } onenc_flags_t;

  typedef struct packed {
    logic [NUM_BITS-1:0] num_u;
    logic [NUM_BITS-1:0] num_v;
    logic [DEN_BITS-1:0] den;
    onenc_flags_t        flags;
  } onenc_div_in_t;

  typedef struct packed {
    logic [QUOT_BITS-1:0] quot_u;
    logic [QUOT_BITS-1:0] quot_v;
    onenc_flags_t         flags;
  } onenc_div_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/onenc_front.sv
// ---------------------------------------------------------------------------
// Octahedral normal encoder front end
// Three stages: magnitudes, L1 norm and fold, dividend and divisor.
// ---------------------------------------------------------------------------
`default_nettype none
`include "octahedral_normal_encoder_defines.svh"

module onenc_front
  import onenc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  onenc_in_t     in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output onenc_div_in_t out_word
);

  localparam int STAGES = 3;

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] adv;

  for (genvar k = 0; k < STAGES; k++) begin : g_adv
    assign adv[k] = !out_stall || !(&v_r[STAGES-1:k]);
  end

  assign in_stall = !adv[0];

  // stage 1: magnitudes and signs
  logic [COMP_BITS-1:0] rx, ry, rz;
  logic [COMP_BITS-1:0] ax_nxt, ay_nxt, az_nxt;
  logic [COMP_BITS-1:0] ax_r, ay_r, az_r;
  logic                 nx_r, ny_r, nz_r;

  always_comb begin
    rx = in_word.normal_x;
    ry = in_word.normal_y;
    rz = in_word.normal_z;
    ax_nxt = rx[COMP_BITS-1] ? (~rx + 1'b1) : rx;
    ay_nxt = ry[COMP_BITS-1] ? (~ry + 1'b1) : ry;
    az_nxt = rz[COMP_BITS-1] ? (~rz + 1'b1) : rz;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      az_r <= az_nxt;
      nx_r <= rx[COMP_BITS-1];
      ny_r <= ry[COMP_BITS-1];
      nz_r <= rz[COMP_BITS-1];
    end
  end

  // stage 2: norm, folded magnitudes on the lower hemisphere
  logic [SUM_BITS-1:0] s_nxt, mu_nxt, mv_nxt;
  logic [SUM_BITS-1:0] s_r, mu_r, mv_r;
  logic                nu_r, nv_r;

  always_comb begin
    s_nxt  = SUM_BITS'(ax_r) + SUM_BITS'(ay_r) + SUM_BITS'(az_r);
    mu_nxt = nz_r ? (SUM_BITS'(ax_r) + SUM_BITS'(az_r)) : SUM_BITS'(ax_r);
    mv_nxt = nz_r ? (SUM_BITS'(ay_r) + SUM_BITS'(az_r)) : SUM_BITS'(ay_r);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s_r  <= s_nxt;
      mu_r <= mu_nxt;
      mv_r <= mv_nxt;
      nu_r <= nx_r;
      nv_r <= ny_r;
    end
  end

  // stage 3: dividend 65534*mag + s (rounds half up), divisor 2*s
  onenc_div_in_t word_nxt, word_r;

  always_comb begin
    word_nxt.num_u = {mu_r, 16'b0} - NUM_BITS'({mu_r, 1'b0}) + NUM_BITS'(s_r);
    word_nxt.num_v = {mv_r, 16'b0} - NUM_BITS'({mv_r, 1'b0}) + NUM_BITS'(s_r);
    word_nxt.den   = {s_r, 1'b0};
    word_nxt.flags.neg_u = nu_r;
    word_nxt.flags.neg_v = nv_r;
    word_nxt.flags.zero  = (s_r == '0);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      word_r <= word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      if (adv[1]) v_r[1] <= v_r[0];
      if (adv[2]) v_r[2] <= v_r[1];
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_word  = word_r;

  `ONENC_ASSERT_IMP(a_zero_den, clk, rst_n, out_valid, out_word.flags.zero == (out_word.den == '0))

endmodule

`default_nettype wire

>>> hw/rtl/onenc_div.sv
// ---------------------------------------------------------------------------
// Octahedral normal encoder divider
// Two-lane restoring divider, one quotient bit per pipeline stage.
// ---------------------------------------------------------------------------
`default_nettype none
`include "octahedral_normal_encoder_defines.svh"

module onenc_div
  import onenc_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  onenc_div_in_t  in_word,
  output logic           out_valid,
  input  logic           out_stall,
  output onenc_div_out_t out_word
);

  localparam int LAST = QUOT_BITS - 1;

  logic [QUOT_BITS-1:0] v_r;
  logic [QUOT_BITS-1:0] adv;

  logic [NUM_BITS-1:0]  rem_u_r [LAST];
  logic [NUM_BITS-1:0]  rem_v_r [LAST];
  logic [DEN_BITS-1:0]  den_r   [LAST];
  logic [QUOT_BITS-1:0] qu_r    [QUOT_BITS];
  logic [QUOT_BITS-1:0] qv_r    [QUOT_BITS];
  onenc_flags_t         flg_r   [QUOT_BITS];

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
    localparam int SHIFT = QUOT_BITS - 1 - k;

    logic                 valid_in;
    logic [NUM_BITS-1:0]  rem_u_in, rem_v_in, dsh;
    logic [DEN_BITS-1:0]  den_in;
    logic [QUOT_BITS-1:0] qu_in, qv_in;
    onenc_flags_t         flg_in;
    logic [NUM_BITS-1:0]  rem_u_nxt, rem_v_nxt;
    logic [QUOT_BITS-1:0] qu_nxt, qv_nxt;

    assign adv[k] = !out_stall || !(&v_r[LAST:k]);

    if (k == 0) begin : g_head
      assign valid_in = in_valid;
      assign rem_u_in = in_word.num_u;
      assign rem_v_in = in_word.num_v;
      assign den_in   = in_word.den;
      assign qu_in    = '0;
      assign qv_in    = '0;
      assign flg_in   = in_word.flags;
    end else begin : g_body
      assign valid_in = v_r[k-1];
      assign rem_u_in = rem_u_r[k-1];
      assign rem_v_in = rem_v_r[k-1];
      assign den_in   = den_r[k-1];
      assign qu_in    = qu_r[k-1];
      assign qv_in    = qv_r[k-1];
      assign flg_in   = flg_r[k-1];
    end

    // try the divisor at this bit weight, keep the remainder when it fits
    always_comb begin
      dsh       = NUM_BITS'(den_in) << SHIFT;
      rem_u_nxt = rem_u_in;
      rem_v_nxt = rem_v_in;
      qu_nxt    = qu_in;
      qv_nxt    = qv_in;
      if (rem_u_in >= dsh) begin
        rem_u_nxt     = rem_u_in - dsh;
        qu_nxt[SHIFT] = 1'b1;
      end
      if (rem_v_in >= dsh) begin
        rem_v_nxt     = rem_v_in - dsh;
        qv_nxt[SHIFT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        qu_r[k]  <= qu_nxt;
        qv_r[k]  <= qv_nxt;
        flg_r[k] <= flg_in;
      end
    end

    if (k < LAST) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv[k]) begin
          rem_u_r[k] <= rem_u_nxt;
          rem_v_r[k] <= rem_v_nxt;
          den_r[k]   <= den_in;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv[k]) begin
        v_r[k] <= valid_in;
      end
    end
  end

  assign in_stall        = !adv[0];
  assign out_valid       = v_r[LAST];
  assign out_word.quot_u = qu_r[LAST];
  assign out_word.quot_v = qv_r[LAST];
  assign out_word.flags  = flg_r[LAST];

  `ONENC_ASSERT_NEXT(a_div_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

`default_nettype wire

>>> hw/rtl/onenc_pack.sv
// ---------------------------------------------------------------------------
// Octahedral normal encoder output stage
// Applies signs, packs both halves and holds the result word.
// ---------------------------------------------------------------------------
`default_nettype none

module onenc_pack
  import onenc_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  onenc_div_out_t in_word,
  output logic           out_valid,
  input  logic           out_stall,
  output onenc_out_t     out_word
);

  logic                 out_valid_r;
  logic                 adv;
  logic [HALF_BITS-1:0] mu, mv, hu, hv;
  onenc_out_t           word_nxt, word_r;

  assign adv = !out_valid_r || !out_stall;

  always_comb begin
    mu = HALF_BITS'(in_word.quot_u);
    mv = HALF_BITS'(in_word.quot_v);
    hu = in_word.flags.neg_u ? (~mu + 1'b1) : mu;
    hv = in_word.flags.neg_v ? (~mv + 1'b1) : mv;
    word_nxt.was_zero    = in_word.flags.zero;
    // zero vector falls back to the up normal, which packs to zero
    word_nxt.packed_word = in_word.flags.zero ? '0 : {hv, hu};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_r <= word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid;
    end
  end

  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

>>> hw/rtl/octahedral_normal_encoder.sv
// ---------------------------------------------------------------------------
// Octahedral normal encoder, snorm16 per axis
// Pipeline of 3 front stages, 15 divider stages and 1 output register.
// Throughput one word per cycle while out_stall stays low; each divider stage resolves one quotient bit.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// ---------------------------------------------------------------------------
`default_nettype none
`include "octahedral_normal_encoder_defines.svh"

module octahedral_normal_encoder
  import onenc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  onenc_in_t  in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output onenc_out_t out_word
);

  // The encoding divides each folded magnitude by the L1 norm s:
  //   q = floor((2*32767*mag + s) / (2*s))
  // which is round-half-away on the magnitude; the sign is applied last.
  // Every stage advances when its downstream slot is empty or moving, so
  // bubbles collapse and a stalled result does not block upstream words
  // until the whole pipe is full.

  logic           fr_valid, fr_stall;
  onenc_div_in_t  fr_word;
  logic           dv_valid, dv_stall;
  onenc_div_out_t dv_word;

  // magnitudes, norm, fold, dividend and divisor
  onenc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (fr_valid),
    .out_stall (fr_stall),
    .out_word  (fr_word)
  );

  // both quotients, one bit per stage
  onenc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_stall  (fr_stall),
    .in_word   (fr_word),
    .out_valid (dv_valid),
    .out_stall (dv_stall),
    .out_word  (dv_word)
  );

  // sign, pack, hold the result word
  onenc_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_stall  (dv_stall),
    .in_word   (dv_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // a zero vector must come out as the packed up normal
  `ONENC_ASSERT_IMP(a_zero_word, clk, rst_n, out_valid && out_word.was_zero, out_word.packed_word == '0)
  // magnitudes stay within 32767, so the most negative code never appears
  `ONENC_ASSERT_IMP(a_half_range, clk, rst_n, out_valid, (out_word.packed_word[15:0] != 16'h8000) && (out_word.packed_word[31:16] != 16'h8000))
  // the input stalls only when every later stage pushes back
  `ONENC_ASSERT_IMP(a_backpressure, clk, rst_n, in_stall, fr_stall && dv_stall && out_stall)

endmodule

`default_nettype wire

>>> tb/octahedral_normal_encoder_tb.sv
// ---------------------------------------------------------------------------
// Octahedral normal encoder testbench
// Drives normal vectors into the encoder and compares each packed snorm16
// word with a table entry or an in-bench prediction of the octahedral map.
// A directed table covers the axes, extremes, zero vector, rounding ties.
// Random vectors follow. Both handshake sides idle at random, and one long
// receiver hold-off backs up the pipeline.
// ---------------------------------------------------------------------------
module octahedral_normal_encoder_tb;
  import onenc_pkg::*;

  localparam longint unsigned OCT_SCALE = 32767;
  localparam int RAND_ITEMS   = 500;
  localparam int DRAIN_CYCLES = 40;      // pipeline is 19 deep; leave margin
  localparam int HOLD_OFF     = 300;     // long receiver stall
  localparam int SQUEEZE_AT   = 200;     // random item that starts the hold-off
  localparam int SQUEEZE_LEN  = 80;      // back-to-back items offered meanwhile
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam logic signed [COMP_BITS-1:0] COMP_MAX = 24'sh7FFFFF;
  localparam logic signed [COMP_BITS-1:0] COMP_MIN = 24'sh800000;

  // One row of the directed table. When known is set, the expected word is
  // taken from the row; otherwise the predictor supplies it.
  typedef struct packed {
    logic signed [COMP_BITS-1:0] x;
    logic signed [COMP_BITS-1:0] y;
    logic signed [COMP_BITS-1:0] z;
    logic                        known;
    logic [2*HALF_BITS-1:0]      word;
    logic                        zero;
  } vec_row_t;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  onenc_in_t  in_word   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  onenc_out_t out_word;

  onenc_out_t  pending_codes[$];   // expected words, oldest first
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          squeeze_req = 1'b0;

  vec_row_t directed_rows [0:22] = '{
    // zero vector: falls back to the up normal, flag raised
    '{24'sd0,    24'sd0,    24'sd0,    1'b1, 32'h0000_0000, 1'b1},
    // the four in-plane axes hit the midpoints of the square's edges
    '{24'sd1,    24'sd0,    24'sd0,    1'b1, 32'h0000_7FFF, 1'b0},
    '{-24'sd1,   24'sd0,    24'sd0,    1'b1, 32'h0000_8001, 1'b0},
    '{24'sd0,    24'sd1,    24'sd0,    1'b1, 32'h7FFF_0000, 1'b0},
    '{24'sd0,    -24'sd1,   24'sd0,    1'b1, 32'h8001_0000, 1'b0},
    // straight up encodes to the center
    '{24'sd0,    24'sd0,    24'sd1,    1'b1, 32'h0000_0000, 1'b0},
    // straight down folds to a corner; zero x and y count as positive
    '{24'sd0,    24'sd0,    -24'sd1,   1'b1, 32'h7FFF_7FFF, 1'b0},
    // full-scale components
    '{COMP_MAX,  24'sd0,    24'sd0,    1'b1, 32'h0000_7FFF, 1'b0},
    '{COMP_MIN,  24'sd0,    24'sd0,    1'b1, 32'h0000_8001, 1'b0},
    '{24'sd0,    24'sd0,    COMP_MIN,  1'b1, 32'h7FFF_7FFF, 1'b0},
    '{24'sd0,    24'sd0,    COMP_MAX,  1'b1, 32'h0000_0000, 1'b0},
    // exact half: rounds away from zero
    '{24'sd1,    24'sd1,    24'sd0,    1'b1, 32'h4000_4000, 1'b0},
    '{-24'sd1,   -24'sd1,   24'sd0,    1'b1, 32'hC000_C000, 1'b0},
    // extremes in four sign patterns
    '{COMP_MAX,  COMP_MAX,  COMP_MAX,  1'b0, 32'h0, 1'b0},
    '{COMP_MIN,  COMP_MIN,  COMP_MIN,  1'b0, 32'h0, 1'b0},
    '{COMP_MIN,  COMP_MAX,  COMP_MIN,  1'b0, 32'h0, 1'b0},
    '{COMP_MAX,  COMP_MIN,  COMP_MAX,  1'b0, 32'h0, 1'b0},
    // mixed signs and zero components, mostly lower hemisphere; zero vector last
    '{24'sd3,    -24'sd5,   -24'sd7,   1'b0, 32'h0, 1'b0},
    '{-24'sd2,   24'sd0,    -24'sd2,   1'b0, 32'h0, 1'b0},
    '{24'sd0,    -24'sd3,   -24'sd1,   1'b0, 32'h0, 1'b0},
    '{24'sd1,    24'sd2,    24'sd3,    1'b0, 32'h0, 1'b0},
    '{-24'sd1,   -24'sd1,   -24'sd1,   1'b0, 32'h0, 1'b0},
    '{24'sd0,    24'sd0,    24'sd0,    1'b1, 32'h0000_0000, 1'b1}
  };

  octahedral_normal_encoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Round 32767*mag/l1 half away from zero, then apply the sign as a 16-bit
  // two's complement half word.
  function automatic logic [HALF_BITS-1:0] snorm_half(input logic neg,
                                                      input longint unsigned mag,
                                                      input longint unsigned l1);
    longint unsigned q;
    logic [HALF_BITS-1:0] m;
    q = (2 * mag * OCT_SCALE + l1) / (2 * l1);
    m = q[HALF_BITS-1:0];
    return neg ? -m : m;
  endfunction

  // Predict the encoded word for one normal.
  function automatic onenc_out_t encode_normal(input onenc_in_t vec);
    longint signed   x, y, z;
    longint unsigned ax, ay, az, l1, mu, mv;
    onenc_out_t      code;
    x  = $signed(vec.normal_x);
    y  = $signed(vec.normal_y);
    z  = $signed(vec.normal_z);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    l1 = ax + ay + az;
    if (l1 == 0) begin
      code.packed_word = '0;
      code.was_zero    = 1'b1;
      return code;
    end
    // upper hemisphere projects straight down; lower folds over the edges
    mu = (z >= 0) ? ax : ax + az;
    mv = (z >= 0) ? ay : ay + az;
    code.packed_word = {snorm_half(y < 0, mv, l1), snorm_half(x < 0, mu, l1)};
    code.was_zero    = 1'b0;
    return code;
  endfunction

  // Draw one component: full range half the time, with small, zero and extreme
  // values mixed in so that ties, folds and overflow edges come up often.
  function automatic logic signed [COMP_BITS-1:0] draw_component();
    logic signed [COMP_BITS-1:0] c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      c = COMP_BITS'($urandom());
    end else if (pick < 70) begin
      c = COMP_BITS'($urandom_range(1, 15));
      if ($urandom_range(0, 1)) c = -c;
    end else if (pick < 85) begin
      c = '0;
    end else begin
      c = $urandom_range(0, 1) ? COMP_MAX : COMP_MIN;
    end
    return c;
  endfunction

  // Offer one word after an idle gap and hold it until the encoder takes it.
  // Leave in_valid high on return so a gapless next word needs no toggle.
  task automatic offer_vector(input onenc_in_t vec, input onenc_out_t code,
                              input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= vec;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_codes.push_back(code);
  endtask

  // Sender: reset, directed table, random vectors, then drain and report.
  initial begin : stimulus
    onenc_in_t  vec;
    onenc_out_t code;
    int         gap;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      vec.normal_x = directed_rows[r].x;
      vec.normal_y = directed_rows[r].y;
      vec.normal_z = directed_rows[r].z;
      if (directed_rows[r].known) begin
        code.packed_word = directed_rows[r].word;
        code.was_zero    = directed_rows[r].zero;
      end else begin
        code = encode_normal(vec);
      end
      offer_vector(vec, code, $urandom_range(0, 9));
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 3) begin
        vec = '0;
      end else begin
        vec.normal_x = draw_component();
        vec.normal_y = draw_component();
        vec.normal_z = draw_component();
      end
      // ask the receiver to hold off, then keep offering back to back
      if (i == SQUEEZE_AT) squeeze_req = 1'b1;
      if (i >= SQUEEZE_AT && i < SQUEEZE_AT + SQUEEZE_LEN) gap = 0;
      else if (i % 100 >= 80) gap = 0;
      else gap = $urandom_range(0, 9);
      offer_vector(vec, encode_normal(vec), gap);
    end
    in_valid <= 1'b0;

    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("octahedral_normal_encoder test passed");
    end else begin
      $display("octahedral_normal_encoder test failed");
    end
    $finish;
  end

  // Receiver: stall a random number of cycles before each word, with a
  // stretch of no stalls every so often and one long hold-off on request.
  initial begin : receiver
    int hold;
    int rx_count;
    bit squeeze_done;
    rx_count     = 0;
    squeeze_done = 1'b0;
    forever begin
      if (squeeze_req && !squeeze_done) begin
        hold         = HOLD_OFF;
        squeeze_done = 1'b1;
      end else if (rx_count % 90 >= 70) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 9);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_valid === 1'b1));
      rx_count++;
    end
  end

  // Compare every accepted word with the oldest expectation.
  always @(posedge clk) begin
    onenc_out_t code;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_codes.size() == 0) begin
        $error("unexpected word: packed_word %h was_zero %b",
               out_word.packed_word, out_word.was_zero);
        mismatch_count++;
      end else begin
        code = pending_codes.pop_front();
        if (out_word.packed_word !== code.packed_word) begin
          $error("packed_word: expected %h, got %h",
                 code.packed_word, out_word.packed_word);
          mismatch_count++;
        end
        if (out_word.was_zero !== code.was_zero) begin
          $error("was_zero: expected %b, got %b", code.was_zero, out_word.was_zero);
          mismatch_count++;
        end
      end
    end
  end

  // Stop a hung run.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("octahedral_normal_encoder test failed");
    $finish;
  end

endmodule
